[hdl/assert_macros.svh]
// Assertion macros shared by the fan controller RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define SCFP_ASSERT_ALWAYS(lbl, ck, rn, prop) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) \
    else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define SCFP_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hdl/scfp_pkg.sv]
// Types, constants and register codes of the serial-commanded fan controller.
`default_nettype none

package scfp_pkg;

  localparam int BYTE_W   = 8;
  localparam int COUNT_W  = 16;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 3;
  localparam int RXCNT_W  = 3;
  localparam int CMD_LEN  = 4;

  // Register reset values
  localparam logic [BYTE_W-1:0]  LOW_ON_RST   = 8'd7;
  localparam logic [BYTE_W-1:0]  MID_ON_RST   = 8'd9;
  localparam logic [BYTE_W-1:0]  HIGH_ON_RST  = 8'd15;
  localparam logic [BYTE_W-1:0]  PERIOD_RST   = 8'd12;
  localparam logic [COUNT_W-1:0] AUTO_OFF_RST = 16'd12000;
  localparam logic [BYTE_W-1:0]  IDLE_LIM_RST = 8'd20;

  // Command characters
  localparam logic [BYTE_W-1:0] CH_T    = 8'h54;
  localparam logic [BYTE_W-1:0] CH_Z    = 8'h5A;
  localparam logic [BYTE_W-1:0] CH_G    = 8'h47;
  localparam logic [BYTE_W-1:0] CH_S    = 8'h53;
  localparam logic [BYTE_W-1:0] CH_D    = 8'h44;
  localparam logic [BYTE_W-1:0] CH_ZERO = 8'h30;
  localparam logic [BYTE_W-1:0] CH_ONE  = 8'h31;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_BYTE = 1'b1
  } scfp_op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOW_ON   = 3'd0,
    REG_MID_ON   = 3'd1,
    REG_HIGH_ON  = 3'd2,
    REG_PERIOD   = 3'd3,
    REG_AUTO_OFF = 3'd4,
    REG_IDLE_LIM = 3'd5
  } scfp_reg_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  low_on_ticks;
    logic [BYTE_W-1:0]  mid_on_ticks;
    logic [BYTE_W-1:0]  high_on_ticks;
    logic [BYTE_W-1:0]  period_ticks;
    logic [COUNT_W-1:0] auto_off_ticks;
    logic [BYTE_W-1:0]  idle_limit;
  } scfp_cfg_t;

  typedef struct packed {
    logic              fan_on;
    logic              running;
    logic              auto_off_armed;
    logic              echo_valid;
    logic [BYTE_W-1:0] echo_byte;
  } scfp_res_t;

endpackage

`default_nettype wire

[hdl/scfp_if.sv]
// Valid/ready channel interfaces for input items and results.
`default_nettype none

interface scfp_in_if;
  import scfp_pkg::*;
  logic              valid;
  logic              ready;
  logic              opcode;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output opcode, output rx_byte, input ready);
  modport sink   (input valid, input opcode, input rx_byte, output ready);
endinterface

interface scfp_out_if;
  import scfp_pkg::*;
  logic              valid;
  logic              ready;
  logic              fan_on;
  logic              running;
  logic              auto_off_armed;
  logic              echo_valid;
  logic [BYTE_W-1:0] echo_byte;

  modport source (output valid, output fan_on, output running, output auto_off_armed,
                  output echo_valid, output echo_byte, input ready);
  modport sink   (input valid, input fan_on, input running, input auto_off_armed,
                  input echo_valid, input echo_byte, output ready);
endinterface

`default_nettype wire

[hdl/scfp_cfg_regs.sv]
// Configuration register file of the fan controller.
`default_nettype none

module scfp_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [scfp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [scfp_pkg::CFG_W-1:0]     cfg_wdata,
  output scfp_pkg::scfp_cfg_t                 cfg
);
  import scfp_pkg::*;

  scfp_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.low_on_ticks   <= LOW_ON_RST;
      cfg_r.mid_on_ticks   <= MID_ON_RST;
      cfg_r.high_on_ticks  <= HIGH_ON_RST;
      cfg_r.period_ticks   <= PERIOD_RST;
      cfg_r.auto_off_ticks <= AUTO_OFF_RST;
      cfg_r.idle_limit     <= IDLE_LIM_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LOW_ON:   cfg_r.low_on_ticks   <= cfg_wdata[BYTE_W-1:0];
        REG_MID_ON:   cfg_r.mid_on_ticks   <= cfg_wdata[BYTE_W-1:0];
        REG_HIGH_ON:  cfg_r.high_on_ticks  <= cfg_wdata[BYTE_W-1:0];
        REG_PERIOD:   cfg_r.period_ticks   <= cfg_wdata[BYTE_W-1:0];
        REG_AUTO_OFF: cfg_r.auto_off_ticks <= cfg_wdata[COUNT_W-1:0];
        REG_IDLE_LIM: cfg_r.idle_limit     <= cfg_wdata[BYTE_W-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

[hdl/scfp_core.sv]
// Fan state, PWM phase, auto-off counter and command buffer decode.
`default_nettype none

`include "assert_macros.svh"

module scfp_core (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        step,
  input  wire logic                        opcode,
  input  wire logic [scfp_pkg::BYTE_W-1:0] rx_byte,
  input  scfp_pkg::scfp_cfg_t              cfg,
  output scfp_pkg::scfp_res_t              res
);
  import scfp_pkg::*;

  logic                run_r, run_nxt;
  logic [BYTE_W-1:0]   phase_r, phase_nxt;
  logic [BYTE_W-1:0]   thr_r, thr_nxt;
  logic                armed_r, armed_nxt;
  logic [COUNT_W-1:0]  cnt_r, cnt_nxt;
  logic [BYTE_W-1:0]   idle_r, idle_nxt;
  logic [RXCNT_W-1:0]  rxcnt_r, rxcnt_nxt;
  logic                drive_r, drive_nxt;
  logic [BYTE_W-1:0]   cmd_r   [CMD_LEN];
  logic [BYTE_W-1:0]   cmd_nxt [CMD_LEN];

  logic                is_byte;
  logic [BYTE_W-1:0]   phase_inc;
  logic [COUNT_W-1:0]  cnt_inc;
  logic [BYTE_W-1:0]   idle_sat;
  logic                full;

  assign is_byte   = (opcode == OP_BYTE);
  assign phase_inc = phase_r + 8'd1;
  assign cnt_inc   = cnt_r + 16'd1;
  assign idle_sat  = (idle_r == 8'hFF) ? idle_r : idle_r + 8'd1;
  assign full      = (rxcnt_r >= 3'd3);

  always_comb begin
    run_nxt   = run_r;
    phase_nxt = phase_r;
    thr_nxt   = thr_r;
    armed_nxt = armed_r;
    cnt_nxt   = cnt_r;
    idle_nxt  = idle_r;
    rxcnt_nxt = rxcnt_r;
    drive_nxt = drive_r;
    cmd_nxt   = cmd_r;

    if (!is_byte) begin
      if (run_r) begin
        priority if (phase_inc <= thr_r) begin
          phase_nxt = phase_inc;
          drive_nxt = 1'b1;
        end else if (phase_inc <= cfg.period_ticks) begin
          phase_nxt = phase_inc;
          drive_nxt = 1'b0;
        end else begin
          phase_nxt = '0;  // wrap, drive unchanged
        end
        if (armed_r) begin
          if (cnt_inc >= cfg.auto_off_ticks) begin
            drive_nxt = 1'b0;
            run_nxt   = 1'b0;
            armed_nxt = 1'b0;
            cnt_nxt   = '0;
          end else begin
            cnt_nxt = cnt_inc;
          end
        end
      end
      idle_nxt = idle_sat;
      // empty the buffer after too long without a byte
      if (idle_sat >= cfg.idle_limit) begin
        rxcnt_nxt = '0;
      end
    end else begin
      idle_nxt = '0;
      if (rxcnt_r < 3'd4) begin
        cmd_nxt[rxcnt_r[1:0]] = rx_byte;
        rxcnt_nxt             = rxcnt_r + 3'd1;
      end
      if (full) begin
        priority if (cmd_nxt[0] == CH_T && cmd_nxt[1] == CH_Z &&
                     cmd_nxt[2] == CH_ZERO && cmd_nxt[3] == CH_ZERO) begin
          drive_nxt = 1'b0;
          run_nxt   = 1'b0;
        end else if (cmd_nxt[1] == CH_S && cmd_nxt[2] == CH_ZERO &&
                     (cmd_nxt[0] == CH_G || cmd_nxt[0] == CH_Z ||
                      cmd_nxt[0] == CH_D)) begin
          run_nxt   = 1'b1;
          phase_nxt = '0;
          cnt_nxt   = '0;
          priority if (cmd_nxt[0] == CH_G) thr_nxt = cfg.high_on_ticks;
          else if (cmd_nxt[0] == CH_Z)     thr_nxt = cfg.mid_on_ticks;
          else                             thr_nxt = cfg.low_on_ticks;
          priority if (cmd_nxt[3] == CH_ZERO) armed_nxt = 1'b0;
          else if (cmd_nxt[3] == CH_ONE)      armed_nxt = 1'b1;
          else                                armed_nxt = armed_r;
        end else begin
          run_nxt = run_r;  // unknown command
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r   <= 1'b1;
      phase_r <= '0;
      thr_r   <= LOW_ON_RST;
      armed_r <= 1'b0;
      cnt_r   <= '0;
      idle_r  <= '0;
      rxcnt_r <= '0;
      drive_r <= 1'b0;
    end else if (step) begin
      run_r   <= run_nxt;
      phase_r <= phase_nxt;
      thr_r   <= thr_nxt;
      armed_r <= armed_nxt;
      cnt_r   <= cnt_nxt;
      idle_r  <= idle_nxt;
      rxcnt_r <= rxcnt_nxt;
      drive_r <= drive_nxt;
    end
  end

  // command buffer holds no reset value
  always_ff @(posedge clk) begin
    if (step) begin
      cmd_r <= cmd_nxt;
    end
  end

  assign res.fan_on         = drive_nxt;
  assign res.running        = run_nxt;
  assign res.auto_off_armed = armed_nxt;
  assign res.echo_valid     = is_byte;
  assign res.echo_byte      = is_byte ? rx_byte : '0;

  `SCFP_ASSERT_ALWAYS(a_rxcnt_max, clk, rst_n, rxcnt_r <= 3'd4)
  `SCFP_ASSERT_NEXT(a_byte_clears_idle, clk, rst_n, step && is_byte, idle_r == '0)
  `SCFP_ASSERT_NEXT(a_stopped_phase_holds, clk, rst_n, step && !is_byte && !run_r,
                    $stable(phase_r) && !run_r)

endmodule

`default_nettype wire

[hdl/serial_commanded_fan_pwm_unit.sv]
// Path: input register -> decode/update -> result reg; each result is registered.
// Throughput: one transaction per cycle while the output is not stalled.
// A stalled result holds while the next transaction waits in the input register.
// Reset (rst_n, synchronous, active low): handshake empty, fan enabled, PWM at phase 0,
// drive off, auto-off disarmed, registers at defaults; buffer bytes left unset.
`default_nettype none

`include "assert_macros.svh"

module serial_commanded_fan_pwm_unit (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  scfp_in_if.sink                             in_ch,
  scfp_out_if.source                          out_ch,
  input  wire logic                           cfg_we,
  input  wire logic [scfp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [scfp_pkg::CFG_W-1:0]     cfg_wdata
);
  import scfp_pkg::*;

  scfp_cfg_t         cfg;
  scfp_res_t         res;
  scfp_res_t         out_data_r;
  logic              out_valid_r, out_valid_nxt;
  logic              in_q_valid_r, in_q_valid_nxt;
  logic              in_q_opcode_r;
  logic [BYTE_W-1:0] in_q_byte_r;
  logic              advance;
  logic              in_take;

  assign advance = in_q_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_q_valid_r || advance;
  assign in_take = in_ch.valid && in_ch.ready;

  always_comb begin
    in_q_valid_nxt = in_q_valid_r;
    if (in_take)      in_q_valid_nxt = 1'b1;
    else if (advance) in_q_valid_nxt = 1'b0;
    out_valid_nxt = out_valid_r;
    if (advance)           out_valid_nxt = 1'b1;
    else if (out_ch.ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_q_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      in_q_valid_r <= in_q_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_q_opcode_r <= in_ch.opcode;
      in_q_byte_r   <= in_ch.rx_byte;
    end
    if (advance) begin
      out_data_r <= res;
    end
  end

  scfp_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  scfp_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .opcode  (in_q_opcode_r),
    .rx_byte (in_q_byte_r),
    .cfg     (cfg),
    .res     (res)
  );

  assign out_ch.valid          = out_valid_r;
  assign out_ch.fan_on         = out_data_r.fan_on;
  assign out_ch.running        = out_data_r.running;
  assign out_ch.auto_off_armed = out_data_r.auto_off_armed;
  assign out_ch.echo_valid     = out_data_r.echo_valid;
  assign out_ch.echo_byte      = out_data_r.echo_byte;

  `SCFP_ASSERT_NEXT(a_advance_fills_out, clk, rst_n, advance, out_valid_r)
  `SCFP_ASSERT_NEXT(a_held_item_kept, clk, rst_n, in_q_valid_r && !advance,
                    in_q_valid_r && $stable(in_q_byte_r) && $stable(in_q_opcode_r))
  `SCFP_ASSERT_ALWAYS(a_no_take_when_full, clk, rst_n,
                      !(in_q_valid_r && !advance && in_ch.ready))

endmodule

`default_nettype wire
